FILE: design/transfer_record_parser_defines.svh
// Assertion helpers shared by the parser modules.
// Each use expects signals named clk and rst_n in the enclosing module.
`ifndef TRANSFER_RECORD_PARSER_DEFINES_SVH
`define TRANSFER_RECORD_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define TPR_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define TPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/tpr_pkg.sv
package tpr_pkg;

    // Build defaults
    localparam int DEF_MAX_POSTINGS = 64;
    localparam int DEF_QUEUE_DEPTH  = 4;

    // Field and state widths
    localparam int DATA_W      = 8;
    localparam int WORD_W      = 64;
    localparam int COUNT_W     = 32;
    localparam int BOUND_W     = 7;
    localparam int POS_W       = 11;
    localparam int NUM_W       = 6;
    localparam int CFG_INDEX_W = 1;

    // Record layout
    localparam int KEY_BYTES     = 8;
    localparam int HEADER_BYTES  = 12;
    localparam int POSTING_BYTES = 16;
    localparam int ACCOUNT_BYTES = 8;

    // Byte position saturates here
    localparam logic [POS_W-1:0] POS_LIMIT = {POS_W{1'b1}};

    // Register reset values
    localparam logic [BOUND_W-1:0] MIN_POSTINGS_RESET = BOUND_W'(1);
    localparam logic [BOUND_W-1:0] MAX_POSTINGS_RESET = BOUND_W'(64);

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_POSTINGS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_POSTINGS = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_SHORT     = 2'd1,
        STATUS_BAD_COUNT = 2'd2,
        STATUS_LENGTH    = 2'd3
    } status_t;

    typedef enum logic {
        KIND_POSTING = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

    // One queue entry: a completed posting, a record status, or both
    typedef struct packed {
        logic                has_posting;
        logic                has_status;
        status_t             status;
        logic [NUM_W-1:0]    posting_number;
        logic [WORD_W-1:0]   key;
        logic [WORD_W-1:0]   account;
        logic [WORD_W-1:0]   amount;
    } entry_t;

endpackage

FILE: design/tpr_front.sv
`include "transfer_record_parser_defines.svh"

module tpr_front
    import tpr_pkg::*;
#(
    parameter int MAX_POSTINGS = DEF_MAX_POSTINGS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [DATA_W-1:0]      data_byte,
    input  logic                   end_of_record,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BOUND_W-1:0]     cfg_data,
    input  logic                   q_full,
    output logic                   push,
    output entry_t                 push_entry
);

    localparam int CNT_W = $clog2(MAX_POSTINGS + 1);
    localparam int LEN_W = (CNT_W + 5 > POS_W) ? CNT_W + 5 : POS_W;

    logic [BOUND_W-1:0] min_reg;
    logic [BOUND_W-1:0] max_reg;

    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [WORD_W-1:0]  key_reg;
    logic [WORD_W-1:0]  key_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_seen;
    logic [WORD_W-1:0]  account_reg;
    logic [WORD_W-1:0]  account_next;
    logic [WORD_W-1:0]  amount_reg;
    logic [WORD_W-1:0]  amount_next;
    logic [CNT_W-1:0]   posting_reg;
    logic [CNT_W-1:0]   posting_next;

    logic               accept;
    logic               count_ok;
    logic [3:0]         offset;
    logic               emit;
    logic [LEN_W-1:0]   expected_len;

    assign accept   = in_valid && !q_full;
    assign in_stall = q_full;

    // Hold the configured posting bounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_POSTINGS_RESET;
            max_reg <= MAX_POSTINGS_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_MIN_POSTINGS)
            begin
                min_reg <= cfg_data;
            end
            if (cfg_index == CFG_MAX_POSTINGS)
            begin
                max_reg <= cfg_data;
            end
        end
    end

    // Take the posting count as it stands after the current byte
    always_comb
    begin
        count_seen = count_reg;
        if (accept && (pos_reg >= POS_W'(KEY_BYTES)) && (pos_reg < POS_W'(HEADER_BYTES)))
        begin
            count_seen[{pos_reg[1:0], 3'b000} +: DATA_W] = data_byte;
        end
    end

    // Check the count against both bounds and the build limit
    assign count_ok = (count_seen >= COUNT_W'(min_reg))
                   && (count_seen <= COUNT_W'(max_reg))
                   && (count_seen <= COUNT_W'(MAX_POSTINGS));

    // Offset of the current byte within its posting
    assign offset = pos_reg[3:0] - 4'(HEADER_BYTES);

    assign expected_len = LEN_W'(HEADER_BYTES)
                        + {(LEN_W - CNT_W)'(0), count_seen[CNT_W-1:0]} * LEN_W'(POSTING_BYTES);

    // Parse the byte and build the queue entry
    always_comb
    begin
        pos_next     = pos_reg;
        key_next     = key_reg;
        count_next   = count_reg;
        account_next = account_reg;
        amount_next  = amount_reg;
        posting_next = posting_reg;
        emit         = 1'b0;

        if (accept && (pos_reg != POS_LIMIT))
        begin
            if (pos_reg < POS_W'(KEY_BYTES))
            begin
                key_next[{pos_reg[2:0], 3'b000} +: DATA_W] = data_byte;
            end
            else if (pos_reg < POS_W'(HEADER_BYTES))
            begin
                count_next[{pos_reg[1:0], 3'b000} +: DATA_W] = data_byte;
            end
            else
            begin
                if (offset < 4'(ACCOUNT_BYTES))
                begin
                    account_next = {data_byte, account_reg[WORD_W-1:DATA_W]};
                end
                else
                begin
                    amount_next = {data_byte, amount_reg[WORD_W-1:DATA_W]};
                end
                if ((offset == 4'(POSTING_BYTES - 1)) && count_ok
                    && (COUNT_W'(posting_reg) < count_reg))
                begin
                    emit         = 1'b1;
                    posting_next = posting_reg + CNT_W'(1);
                end
            end
            pos_next = pos_reg + POS_W'(1);
        end

        push_entry.has_posting    = emit;
        push_entry.has_status     = end_of_record;
        push_entry.posting_number = NUM_W'(posting_reg);
        push_entry.key            = key_next;
        push_entry.account        = account_reg;
        push_entry.amount         = amount_next;

        // Run the record checks in order
        if (pos_next < POS_W'(HEADER_BYTES))
        begin
            push_entry.status = STATUS_SHORT;
        end
        else if (!count_ok)
        begin
            push_entry.status = STATUS_BAD_COUNT;
        end
        else if (LEN_W'(pos_next) != expected_len)
        begin
            push_entry.status = STATUS_LENGTH;
        end
        else
        begin
            push_entry.status = STATUS_OK;
        end

        // Drop the record state once it closes
        if (accept && end_of_record)
        begin
            pos_next     = '0;
            key_next     = '0;
            count_next   = '0;
            account_next = '0;
            amount_next  = '0;
            posting_next = '0;
        end
    end

    assign push = accept && (emit || end_of_record);

    // Advance the parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            key_reg     <= '0;
            count_reg   <= '0;
            account_reg <= '0;
            amount_reg  <= '0;
            posting_reg <= '0;
        end
        else
        begin
            pos_reg     <= pos_next;
            key_reg     <= key_next;
            count_reg   <= count_next;
            account_reg <= account_next;
            amount_reg  <= amount_next;
            posting_reg <= posting_next;
        end
    end

    `TPR_ASSERT_NEXT(a_record_restarts, accept && end_of_record, pos_reg == '0,
        "byte position not cleared after record end")

endmodule

FILE: design/tpr_queue.sv
`include "transfer_record_parser_defines.svh"

module tpr_queue
    import tpr_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   q_valid,
    output entry_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;

    assign full    = (fill_reg == CNT_W'(DEPTH));
    assign q_valid = (fill_reg != '0);
    assign head    = entry_reg[rd_ptr_reg];

    // Step pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the incoming request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `TPR_ASSERT_IMPLY(a_no_push_when_full, push, !full, "push into a full queue")
    `TPR_ASSERT_IMPLY(a_no_pop_when_empty, pop, q_valid, "pop from an empty queue")

endmodule

FILE: design/tpr_back.sv
`include "transfer_record_parser_defines.svh"

module tpr_back
    import tpr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    input  entry_t                   head,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     item_kind,
    output logic [WORD_W-1:0]        record_key,
    output logic [WORD_W-1:0]        account_id,
    output logic signed [WORD_W-1:0] posting_amount,
    output logic [NUM_W-1:0]         posting_number,
    output logic [1:0]               record_status,
    output logic                     last_of_run
);

    logic               valid_reg;
    logic               valid_next;
    logic               phase_reg;
    logic               phase_next;
    logic               load;

    kind_t              kind_reg;
    kind_t              kind_next;
    logic [WORD_W-1:0]  key_reg;
    logic [WORD_W-1:0]  account_reg;
    logic [WORD_W-1:0]  account_next;
    logic [WORD_W-1:0]  amount_reg;
    logic [WORD_W-1:0]  amount_next;
    logic [NUM_W-1:0]   number_reg;
    logic [NUM_W-1:0]   number_next;
    status_t            status_reg;
    status_t            status_next;
    logic               last_reg;
    logic               last_next;

    assign load = q_valid && (!valid_reg || !out_stall);

    // Pick the next result item from the queue head
    always_comb
    begin
        pop          = 1'b0;
        phase_next   = phase_reg;
        valid_next   = valid_reg && out_stall;
        kind_next    = KIND_STATUS;
        account_next = '0;
        amount_next  = '0;
        number_next  = '0;
        status_next  = head.status;
        last_next    = 1'b1;

        if (load)
        begin
            valid_next = 1'b1;
            if (head.has_posting && !phase_reg)
            begin
                kind_next    = KIND_POSTING;
                account_next = head.account;
                amount_next  = head.amount;
                number_next  = head.posting_number;
                status_next  = STATUS_OK;
                last_next    = 1'b0;
                if (head.has_status)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    pop = 1'b1;
                end
            end
            else
            begin
                phase_next = 1'b0;
                pop        = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg    <= kind_next;
            key_reg     <= head.key;
            account_reg <= account_next;
            amount_reg  <= amount_next;
            number_reg  <= number_next;
            status_reg  <= status_next;
            last_reg    <= last_next;
        end
    end

    assign out_valid      = valid_reg;
    assign item_kind      = kind_reg;
    assign record_key     = key_reg;
    assign account_id     = account_reg;
    assign posting_amount = amount_reg;
    assign posting_number = number_reg;
    assign record_status  = status_reg;
    assign last_of_run    = last_reg;

    `TPR_ASSERT_IMPLY(a_split_entry_held, phase_reg,
        q_valid && head.has_posting && head.has_status,
        "second half of a split entry missing from the queue head")

endmodule

FILE: design/transfer_record_parser.sv
// Transfer record parser: takes a record one byte per request (end_of_record on the
// final byte) and returns a posting item for each completed posting of the declared
// count while that count lies within [min_postings, min(max_postings, MAX_POSTINGS)],
// then one status item (ok, too short, bad count, length mismatch) closing the record.
// Discard a record's posting items unless its status is ok. The front parser takes one
// byte every cycle while the queue is not full; results pass through a QUEUE_DEPTH-entry
// queue and then the registered output. The output register issues one item per cycle
// while out_stall is low; a byte that both completes a posting and ends the record gives
// a posting item and then a status item. The input stalls only when the queue is full.
// Write min_postings and max_postings only while no record is in flight.
module transfer_record_parser
    import tpr_pkg::*;
#(
    parameter int MAX_POSTINGS = DEF_MAX_POSTINGS,
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [DATA_W-1:0]        data_byte,
    input  logic                     end_of_record,
    input  logic                     cfg_write,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [BOUND_W-1:0]       cfg_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     item_kind,
    output logic [WORD_W-1:0]        record_key,
    output logic [WORD_W-1:0]        account_id,
    output logic signed [WORD_W-1:0] posting_amount,
    output logic [NUM_W-1:0]         posting_number,
    output logic [1:0]               record_status,
    output logic                     last_of_run
);

    logic   q_full;
    logic   push;
    entry_t push_entry;
    logic   pop;
    logic   q_valid;
    entry_t head;

    tpr_front #(
        .MAX_POSTINGS (MAX_POSTINGS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_record (end_of_record),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_full        (q_full),
        .push          (push),
        .push_entry    (push_entry)
    );

    tpr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .head       (head)
    );

    tpr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .item_kind      (item_kind),
        .record_key     (record_key),
        .account_id     (account_id),
        .posting_amount (posting_amount),
        .posting_number (posting_number),
        .record_status  (record_status),
        .last_of_run    (last_of_run)
    );

endmodule
